// File: hdl/iads_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iads_pkg;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_SQRT = 3'd4,
		OP_AND  = 3'd5,
		OP_OR   = 3'd6,
		OP_NAND = 3'd7
	} iads_op_t;

	// control that travels beside the data in every stage
	typedef struct packed {
		logic     valid;
		iads_op_t op;
		logic     neg;   // quotient gets negated
		logic     zero;  // divide by zero or root of a negative value
	} iads_ctl_t;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 32;
	localparam int FIELD_W     = 32;

endpackage
`default_nettype wire

// File: hdl/iads_step.sv
`timescale 1ns / 1ps
`default_nettype none
// One pipeline stage: one restoring divide bit and, in the first stages, one root bit.
module iads_step
	import iads_pkg::*;
#(
	parameter int DW      = 32,
	parameter int SQN     = 16,
	parameter bit DO_SQRT = 1'b1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire iads_ctl_t       ctl_i,
	input  wire logic [DW-1:0]   r_i,
	input  wire logic [DW-1:0]   n_i,
	input  wire logic [DW-1:0]   d_i,
	input  wire logic [DW:0]     rem_i,
	input  wire logic [2*SQN-1:0] sv_i,
	input  wire logic [SQN+1:0]  sr_i,
	input  wire logic [SQN-1:0]  sq_i,
	output iads_ctl_t            ctl_o,
	output logic [DW-1:0]        r_o,
	output logic [DW-1:0]        n_o,
	output logic [DW-1:0]        d_o,
	output logic [DW:0]          rem_o,
	output logic [2*SQN-1:0]     sv_o,
	output logic [SQN+1:0]       sr_o,
	output logic [SQN-1:0]       sq_o
);

	logic [DW:0]    div_rs;
	logic           div_ge;
	logic [SQN+1:0] sq_rs;
	logic [SQN+1:0] sq_trial;
	logic           sq_ge;

	assign div_rs   = {rem_i[DW-1:0], n_i[DW-1]};
	assign div_ge   = div_rs >= {1'b0, d_i};
	// top bits of the root remainder are zero before this step
	assign sq_rs    = {sr_i[SQN-1:0], sv_i[2*SQN-1 -: 2]};
	assign sq_trial = {sq_i, 2'b01};
	assign sq_ge    = sq_rs >= sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_o   <= r_i;
			d_o   <= d_i;
			n_o   <= {n_i[DW-2:0], div_ge};
			rem_o <= div_ge ? (div_rs - {1'b0, d_i}) : div_rs;
			if (DO_SQRT) begin
				sv_o <= {sv_i[2*SQN-3:0], 2'b00};
				sr_o <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
				sq_o <= {sq_i[SQN-2:0], sq_ge};
			end else begin
				sv_o <= sv_i;
				sr_o <= sr_i;
				sq_o <= sq_i;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/integer_alu_div_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Integer ALU with divide and square root.
// Input stream s_axis: one item per opcode and operand pair; output stream
// m_axis: one result item for every input item, in order.
// Operations: add, sub, mul (wrapping), signed divide truncating toward zero,
// floor square root of operand_a, and, or, nand. Divide by zero and the root
// of a negative value give 0.
// The pipeline is two stages of operand preparation and multiply, one stage per
// quotient bit (the root bits are formed in the first half of those stages),
// and the output register.
// Throughput is one item per cycle while m_axis is not stalled; every op goes through the same pipeline.
// The whole pipeline advances whenever the output register is empty or being
// taken; while the receiver holds m_axis_tready low with a result waiting,
// every stage holds and s_axis_tready is low, so nothing is lost or repeated.
// Reset clears all valid bits; the block takes items in the first cycle after.
module integer_alu_div_sqrt
	import iads_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// op[2:0], operand_a[34:3], operand_b[66:35], zero pad [71:67]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// result[31:0]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int DW  = DATA_WIDTH;
	localparam int HW  = (DW + 1) / 2;
	localparam int LW  = DW - HW;
	localparam int SQN = (DW + 1) / 2;

	logic adv;
	logic valid_q;

	assign adv           = !valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// input fields
	iads_op_t                  in_op;
	logic signed [FIELD_W-1:0] in_a;
	logic signed [FIELD_W-1:0] in_b;
	logic [DW-1:0]             a_x;
	logic [DW-1:0]             b_x;
	logic [DW-1:0]             a_mag;
	logic [DW-1:0]             b_mag;
	logic [2*HW-1:0]           m00;
	logic [LW-1:0]             m01;
	logic [LW-1:0]             m10;
	iads_ctl_t                 ctl_in;
	logic [DW-1:0]             simple_res;

	assign in_op = iads_op_t'(s_axis_tdata[2:0]);
	assign in_a  = s_axis_tdata[34:3];
	assign in_b  = s_axis_tdata[66:35];
	assign a_x   = DW'(in_a);
	assign b_x   = DW'(in_b);
	assign a_mag = a_x[DW-1] ? (~a_x + 1'b1) : a_x;
	assign b_mag = b_x[DW-1] ? (~b_x + 1'b1) : b_x;

	// low DW bits of the product from three half-width products
	assign m00 = (2*HW)'(a_x[HW-1:0]) * (2*HW)'(b_x[HW-1:0]);
	assign m01 = a_x[LW-1:0] * b_x[DW-1:HW];
	assign m10 = a_x[DW-1:HW] * b_x[LW-1:0];

	always_comb begin
		case (in_op)
			OP_ADD:  simple_res = a_x + b_x;
			OP_SUB:  simple_res = a_x - b_x;
			OP_AND:  simple_res = a_x & b_x;
			OP_OR:   simple_res = a_x | b_x;
			OP_NAND: simple_res = ~(a_x & b_x);
			default: simple_res = '0;
		endcase
	end

	always_comb begin
		ctl_in.valid = s_axis_tvalid;
		ctl_in.op    = in_op;
		ctl_in.neg   = a_x[DW-1] ^ b_x[DW-1];
		case (in_op)
			OP_DIV:  ctl_in.zero = (b_x == '0);
			OP_SQRT: ctl_in.zero = a_x[DW-1];
			default: ctl_in.zero = 1'b0;
		endcase
	end

	// stage 1
	iads_ctl_t     ctl_s1;
	logic [DW-1:0] res_s1;
	logic [DW-1:0] p0_s1;
	logic [LW-1:0] p1_s1;
	logic [LW-1:0] p2_s1;
	logic [DW-1:0] na_s1;
	logic [DW-1:0] nb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1 <= simple_res;
			p0_s1  <= m00[DW-1:0];
			p1_s1  <= m01;
			p2_s1  <= m10;
			na_s1  <= a_mag;
			nb_s1  <= b_mag;
		end
	end

	// stage 2: finish the multiply
	iads_ctl_t     ctl_s2;
	logic [DW-1:0] res_s2;
	logic [DW-1:0] na_s2;
	logic [DW-1:0] nb_s2;
	logic [DW-1:0] mul_sum;

	assign mul_sum = p0_s1 + {LW'(p1_s1 + p2_s1), {HW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= (ctl_s1.op == OP_MUL) ? mul_sum : res_s1;
			na_s2  <= na_s1;
			nb_s2  <= nb_s1;
		end
	end

	// divide / root stages; index 0 is fed from stage 2
	iads_ctl_t        ctl_sn [0:DW];
	logic [DW-1:0]    r_sn   [0:DW];
	logic [DW-1:0]    n_sn   [0:DW];
	logic [DW-1:0]    d_sn   [0:DW];
	logic [DW:0]      rem_sn [0:DW];
	logic [2*SQN-1:0] sv_sn  [0:DW];
	logic [SQN+1:0]   sr_sn  [0:DW];
	logic [SQN-1:0]   sq_sn  [0:DW];

	assign ctl_sn[0] = ctl_s2;
	assign r_sn[0]   = res_s2;
	assign n_sn[0]   = na_s2;
	assign d_sn[0]   = nb_s2;
	assign rem_sn[0] = '0;
	assign sv_sn[0]  = (2*SQN)'(na_s2);
	assign sr_sn[0]  = '0;
	assign sq_sn[0]  = '0;

	for (genvar k = 0; k < DW; k++) begin : g_step
		iads_step #(
			.DW      (DW),
			.SQN     (SQN),
			.DO_SQRT (k < SQN)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctl_i  (ctl_sn[k]),
			.r_i    (r_sn[k]),
			.n_i    (n_sn[k]),
			.d_i    (d_sn[k]),
			.rem_i  (rem_sn[k]),
			.sv_i   (sv_sn[k]),
			.sr_i   (sr_sn[k]),
			.sq_i   (sq_sn[k]),
			.ctl_o  (ctl_sn[k+1]),
			.r_o    (r_sn[k+1]),
			.n_o    (n_sn[k+1]),
			.d_o    (d_sn[k+1]),
			.rem_o  (rem_sn[k+1]),
			.sv_o   (sv_sn[k+1]),
			.sr_o   (sr_sn[k+1]),
			.sq_o   (sq_sn[k+1])
		);
	end

	// output register
	iads_ctl_t     ctl_last;
	logic [DW-1:0] quo;
	logic [DW-1:0] final_res;

	assign ctl_last = ctl_sn[DW];
	assign quo      = n_sn[DW];

	always_comb begin
		case (ctl_last.op)
			OP_DIV: begin
				if (ctl_last.zero) begin
					final_res = '0;
				end else begin
					final_res = ctl_last.neg ? (~quo + 1'b1) : quo;
				end
			end
			OP_SQRT: final_res = ctl_last.zero ? '0 : DW'(sq_sn[DW]);
			default: final_res = r_sn[DW];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= OUT_TDATA_W'(final_res);
		end
	end

	assign m_axis_tvalid = valid_q;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ctl_s1.valid)
		else $error("accepted item not in stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s2) && $stable(ctl_last))
		else $error("pipeline moved during stall");

	a_zero_case: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_last.valid && ctl_last.zero &&
		(ctl_last.op == OP_DIV || ctl_last.op == OP_SQRT) |=> m_axis_tdata == '0)
		else $error("zero case gave nonzero result");

endmodule
`default_nettype wire
